FILE: hdl/dvgr_pkg.sv
// Shared types, constants and the 5x7 font for the decimal value glyph renderer.
// No dependencies; the ROM, digit unit and core files in hdl/ import this package.
`default_nettype none
package dvgr_pkg;

    localparam int MAX_DIGITS  = 5;
    localparam int DIGIT_IDX_W = 3;
    localparam int GLYPH_COLS  = 6;
    localparam int COL_W       = 3;
    localparam int PC_W        = 3;

    localparam logic [COL_W-1:0] LAST_COL = 3'd5;

    // x / 10 == (x * 52429) >> 19 for every x below 81920
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    // glyph codes beyond the ten digits
    localparam logic [3:0] GLYPH_MILLI = 4'd10;
    localparam logic [3:0] GLYPH_VOLT  = 4'd11;

    // program step addresses
    localparam logic [PC_W-1:0] PC_LOAD   = 3'd0;
    localparam logic [PC_W-1:0] PC_DIVIDE = 3'd1;
    localparam logic [PC_W-1:0] PC_DIGITS = 3'd2;
    localparam logic [PC_W-1:0] PC_SPACE  = 3'd3;
    localparam logic [PC_W-1:0] PC_MILLI  = 3'd4;
    localparam logic [PC_W-1:0] PC_VOLT   = 3'd5;

    typedef enum logic [1:0] {
        OP_GOTO,
        OP_LOAD,
        OP_DIVIDE,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        SRC_BLANK,
        SRC_DIGIT,
        SRC_MILLI,
        SRC_VOLT
    } src_t;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_QUOT_MORE,
        COND_DIGITS_LEFT
    } cond_t;

    typedef struct packed {
        op_t             op;
        src_t            src;
        cond_t           cond;
        logic            last;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic load;
        logic divide;
        logic step_down;
    } dp_ctrl_t;

    typedef struct packed {
        logic       quot_more;
        logic       digits_left;
        logic [3:0] digit;
    } dp_stat_t;

    localparam logic [7:0] FONT [12][5] = '{
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
        '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h62, 8'h51, 8'h49, 8'h49, 8'h46},
        '{8'h22, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
        '{8'h2F, 8'h49, 8'h49, 8'h49, 8'h31},
        '{8'h3E, 8'h49, 8'h49, 8'h49, 8'h32},
        '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h26, 8'h49, 8'h49, 8'h49, 8'h3E},
        '{8'h7C, 8'h04, 8'h18, 8'h04, 8'h78},
        '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F}
    };

    // sixth column of every glyph is the blank spacer
    function automatic logic [7:0] glyph_column(input logic [3:0] glyph,
                                                input logic [COL_W-1:0] col);
        logic [7:0] bits;
        bits = 8'h00;
        if ((glyph <= GLYPH_VOLT) && (col < LAST_COL)) begin
            bits = FONT[glyph][col];
        end
        return bits;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/dvgr_ucode_rom.sv
// Control store: one control word per program step of the renderer.
// Depends on dvgr_pkg.
`default_nettype none
module dvgr_ucode_rom (
    input  wire logic [dvgr_pkg::PC_W-1:0] pc,
    output dvgr_pkg::ucode_t               word
);
    import dvgr_pkg::*;

    always_comb
    begin
        case (pc)
            PC_LOAD:   word = '{OP_LOAD,   SRC_BLANK, COND_NEVER,       1'b0, PC_LOAD};
            PC_DIVIDE: word = '{OP_DIVIDE, SRC_BLANK, COND_QUOT_MORE,   1'b0, PC_DIVIDE};
            PC_DIGITS: word = '{OP_EMIT,   SRC_DIGIT, COND_DIGITS_LEFT, 1'b0, PC_DIGITS};
            PC_SPACE:  word = '{OP_EMIT,   SRC_BLANK, COND_NEVER,       1'b0, PC_LOAD};
            PC_MILLI:  word = '{OP_EMIT,   SRC_MILLI, COND_NEVER,       1'b0, PC_LOAD};
            PC_VOLT:   word = '{OP_EMIT,   SRC_VOLT,  COND_ALWAYS,      1'b1, PC_LOAD};
            default:   word = '{OP_GOTO,   SRC_BLANK, COND_ALWAYS,      1'b0, PC_LOAD};
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/dvgr_digit_unit.sv
// Datapath: value register, divide-by-ten step and the decimal digit store.
// Depends on dvgr_pkg.
`default_nettype none
module dvgr_digit_unit #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  dvgr_pkg::dp_ctrl_t          ctrl,
    output dvgr_pkg::dp_stat_t          stat
);
    import dvgr_pkg::*;

    localparam int ProdW = VALUE_WIDTH + 20;

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [3:0]             digit_reg [MAX_DIGITS];
    logic [DIGIT_IDX_W-1:0] idx_reg;
    logic [DIGIT_IDX_W-1:0] idx_next;

    logic [ProdW-1:0]       prod;
    logic [VALUE_WIDTH-1:0] quot;
    logic [VALUE_WIDTH+3:0] quot_x10;
    logic [3:0]             rem;

    always_comb
    begin
        prod     = ProdW'(value_reg) * ProdW'(DIV10_RECIP);
        quot     = prod[DIV10_SHIFT +: VALUE_WIDTH];
        quot_x10 = ({4'b0, quot} << 3) + ({4'b0, quot} << 1);
        rem      = 4'(({4'b0, value_reg} - quot_x10));
    end

    assign stat.quot_more   = (quot != '0) && (idx_reg != DIGIT_IDX_W'(MAX_DIGITS - 1));
    assign stat.digits_left = (idx_reg != '0);
    assign stat.digit       = digit_reg[idx_reg];

    always_comb
    begin
        idx_next = idx_reg;
        if (ctrl.load) begin
            idx_next = '0;
        end else if (ctrl.divide && stat.quot_more) begin
            idx_next = idx_reg + 1'b1;
        end else if (ctrl.step_down) begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load) begin
            value_reg <= value;
        end else if (ctrl.divide) begin
            value_reg          <= quot;
            digit_reg[idx_reg] <= rem;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/decimal_value_glyph_renderer_core.sv
// Flow: the value is accepted on the load step, then one divide-by-ten step per digit,
// then the columns leave through the output register, one column per cycle while
// column_stall is low. A new value is taken only on the load step, after the last column.
// Reset: rst_n clears the program counter, counters and output valid at once.
// Depends on dvgr_pkg, dvgr_ucode_rom and dvgr_digit_unit.
`default_nettype none
module decimal_value_glyph_renderer_core #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        value_valid,
    output      logic        value_stall,
    input  wire logic [15:0] value_in,
    output      logic        column_valid,
    input  wire logic        column_stall,
    output      logic [7:0]  column_bits,
    output      logic        last_column
);
    import dvgr_pkg::*;

    // sequencer state
    logic [PC_W-1:0]  pc_reg;
    logic [PC_W-1:0]  pc_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;

    // output register: parts the sequencer from the consumer
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] bits_reg;
    logic [7:0] bits_next;
    logic       last_reg;
    logic       last_next;

    ucode_t   word;
    dp_ctrl_t dp_ctrl;
    dp_stat_t dp_stat;

    logic       value_take;
    logic       emit_fire;
    logic       step_done;
    logic       cond_true;
    logic [3:0] glyph_sel;

    dvgr_ucode_rom u_rom (
        .pc   (pc_reg),
        .word (word)
    );

    dvgr_digit_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_digits (
        .clk   (clk),
        .rst_n (rst_n),
        .value (value_in[VALUE_WIDTH-1:0]),
        .ctrl  (dp_ctrl),
        .stat  (dp_stat)
    );

    // take a new item only on the load step
    assign value_stall  = (word.op != OP_LOAD);
    assign value_take   = (word.op == OP_LOAD) && value_valid;
    // emit a column whenever the output register is free or draining
    assign emit_fire    = (word.op == OP_EMIT) && (!out_valid_reg || !column_stall);

    // step completion and jump condition
    always_comb
    begin
        case (word.op)
            OP_LOAD:   step_done = value_take;
            OP_DIVIDE: step_done = 1'b1;
            OP_EMIT:   step_done = emit_fire && (col_reg == LAST_COL);
            default:   step_done = 1'b1;
        endcase

        case (word.cond)
            COND_ALWAYS:      cond_true = 1'b1;
            COND_QUOT_MORE:   cond_true = dp_stat.quot_more;
            COND_DIGITS_LEFT: cond_true = dp_stat.digits_left;
            default:          cond_true = 1'b0;
        endcase
    end

    // next program step and glyph column
    always_comb
    begin
        pc_next = pc_reg;
        if (step_done) begin
            pc_next = cond_true ? word.target : pc_reg + 1'b1;
        end

        col_next = col_reg;
        if (emit_fire) begin
            col_next = (col_reg == LAST_COL) ? '0 : col_reg + 1'b1;
        end
    end

    // datapath strobes; step down to the next digit after its spacer column
    always_comb
    begin
        dp_ctrl.load      = value_take;
        dp_ctrl.divide    = (word.op == OP_DIVIDE);
        dp_ctrl.step_down = emit_fire && (word.src == SRC_DIGIT)
                            && (col_reg == LAST_COL) && dp_stat.digits_left;
    end

    // column select and output register next values
    always_comb
    begin
        case (word.src)
            SRC_DIGIT: glyph_sel = dp_stat.digit;
            SRC_MILLI: glyph_sel = GLYPH_MILLI;
            SRC_VOLT:  glyph_sel = GLYPH_VOLT;
            default:   glyph_sel = '0;
        endcase

        out_valid_next = out_valid_reg && column_stall;
        bits_next      = bits_reg;
        last_next      = last_reg;
        if (emit_fire) begin
            out_valid_next = 1'b1;
            bits_next      = (word.src == SRC_BLANK) ? 8'h00 : glyph_column(glyph_sel, col_reg);
            last_next      = word.last && (col_reg == LAST_COL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg        <= PC_LOAD;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        last_reg <= last_next;
    end

    assign column_valid = out_valid_reg;
    assign column_bits  = bits_reg;
    assign last_column  = last_reg;

endmodule
`default_nettype wire

FILE: hdl/dvgr_checker.sv
// Port-level checks on the renderer core, bound to every instance of it.
// Depends on decimal_value_glyph_renderer_core ports only.
`default_nettype none
module dvgr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       value_valid,
    input wire logic       value_stall,
    input wire logic       column_valid,
    input wire logic       column_stall,
    input wire logic [7:0] column_bits,
    input wire logic       last_column
);

    // a stalled column item holds
    a_column_hold: assert property (@(posedge clk) disable iff (!rst_n)
        column_valid && column_stall |=> column_valid && $stable(column_bits)
                                         && $stable(last_column))
        else $error("stalled column item changed");

    // once an item is taken the core is busy rendering it
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && !value_stall |=> value_stall)
        else $error("input taken twice in a row");

    // only the final column may still wait while a new item is offered
    a_idle_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        column_valid && !value_stall |-> last_column)
        else $error("input open while rendering unfinished");

    // the final column of a rendering is always the blank after 'V'
    a_last_blank: assert property (@(posedge clk) disable iff (!rst_n)
        column_valid && last_column |-> column_bits == 8'h00)
        else $error("final column not blank");

endmodule

bind decimal_value_glyph_renderer_core dvgr_checker u_dvgr_checker (.*);
`default_nettype wire
